[rtl/core/sfvm_pkg.sv]
`timescale 1ns / 1ps

package sfvm_pkg;

  localparam int DATA_DEPTH = 1024;
  localparam int ADDR_W = $clog2(DATA_DEPTH);

  localparam logic [3:0] CMD_JABS = 4'd0;
  localparam logic [3:0] CMD_JREL = 4'd1;
  localparam logic [3:0] CMD_CALL = 4'd2;
  localparam logic [3:0] CMD_RET  = 4'd3;
  localparam logic [3:0] CMD_PUSH = 4'd4;
  localparam logic [3:0] CMD_POP  = 4'd5;
  localparam logic [3:0] CMD_SET  = 4'd6;
  localparam logic [3:0] CMD_ADD  = 4'd7;
  localparam logic [3:0] CMD_MUL  = 4'd8;
  localparam logic [3:0] CMD_OUT  = 4'd9;
  localparam logic [3:0] CMD_JNZ  = 4'd10;

  typedef logic [ADDR_W-1:0] addr_t;

  // Instruction in the execute stage, with the fault flags of its two reads.
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
    logic [31:0] arg_third;
    logic        rd_fault0;
    logic        rd_fault1;
  } exec_in_t;

  typedef struct packed {
    logic [31:0] pc_next;
    logic [31:0] fp_next;
    logic        wr_en;
    addr_t       wr_addr;
    logic [31:0] wr_data;
    logic        running;
    logic        shown_valid;
    logic [31:0] shown_offset;
    logic [31:0] shown_value;
    logic        address_fault;
  } exec_out_t;

  function automatic logic addr_fault(input logic [31:0] addr);
    addr_fault = (addr >= 32'(DATA_DEPTH));
  endfunction

endpackage

[rtl/core/sfvm_in_if.sv]
`timescale 1ns / 1ps

interface sfvm_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] arg_first;
  logic signed [31:0] arg_second;
  logic signed [31:0] arg_third;

  modport source (output valid, cmd, arg_first, arg_second, arg_third, input ready);
  modport sink (input valid, cmd, arg_first, arg_second, arg_third, output ready);
endinterface

[rtl/core/sfvm_out_if.sv]
`timescale 1ns / 1ps

interface sfvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_pc;
  logic               running;
  logic               shown_valid;
  logic signed [31:0] shown_offset;
  logic signed [31:0] shown_value;
  logic               address_fault;

  modport source (output valid, next_pc, running, shown_valid, shown_offset, shown_value,
                  address_fault, input ready);
  modport sink (input valid, next_pc, running, shown_valid, shown_offset, shown_value,
                address_fault, output ready);
endinterface

[rtl/core/stack_frame_vm_execute_core.sv]
`timescale 1ns / 1ps
// Pipeline: an input transaction passes the input register, the memory-read register and the
// output register. Throughput: one instruction per cycle while the output is not stalled; the
// fetch stage reads two data words per cycle and the execute stage writes one, with forwarding
// of the frame pointer and the written word. Reset clears the program counter, the valid flags,
// the frame pointer and program_length at once, then the data memory is cleared one word per
// cycle; no input transaction is taken until the clearing is done.

module stack_frame_vm_execute_core
  import sfvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  sfvm_in_if.sink     item,
  sfvm_out_if.source  result
);

  logic        a_valid;
  logic [3:0]  a_cmd;
  logic [31:0] a_first;
  logic [31:0] a_second;
  logic [31:0] a_third;

  logic        b_valid;
  exec_in_t    b_item;
  exec_out_t   ex_out;

  logic [31:0] pc;
  logic [31:0] fp;
  logic [15:0] program_length;

  logic        advance;
  logic        mem_busy;
  logic [31:0] fp_eff;
  logic [31:0] rd_off0;
  logic [31:0] rd_full0;
  logic [31:0] rd_full1;
  logic [31:0] rd_data0;
  logic [31:0] rd_data1;
  logic        mem_wr_en;

  logic               out_valid;
  logic signed [31:0] out_next_pc;
  logic               out_running;
  logic               out_shown_valid;
  logic signed [31:0] out_shown_offset;
  logic signed [31:0] out_shown_value;
  logic               out_address_fault;

  assign advance    = !out_valid || result.ready;
  assign item.ready = !mem_busy && (!a_valid || advance);

  // The frame pointer that the execute stage leaves is used for the reads of the next item.
  assign fp_eff   = b_valid ? ex_out.fp_next : fp;
  assign rd_off0  = (a_cmd == CMD_RET) ? 32'd1 : (a_cmd == CMD_POP) ? 32'd0 : a_first;
  assign rd_full0 = fp_eff + rd_off0;
  assign rd_full1 = fp_eff + a_second;

  assign mem_wr_en = b_valid && advance && ex_out.wr_en;

  sfvm_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (advance),
    .rd_addr0 (rd_full0[ADDR_W-1:0]),
    .rd_addr1 (rd_full1[ADDR_W-1:0]),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (mem_wr_en),
    .wr_addr  (ex_out.wr_addr),
    .wr_data  (ex_out.wr_data),
    .busy     (mem_busy)
  );

  sfvm_exec u_exec (
    .ex_in          (b_item),
    .rd_data0       (rd_data0),
    .rd_data1       (rd_data1),
    .pc             (pc),
    .fp             (fp),
    .program_length (program_length),
    .ex_out         (ex_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_wr_en) begin
      program_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item.ready) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      a_cmd    <= item.cmd;
      a_first  <= item.arg_first;
      a_second <= item.arg_second;
      a_third  <= item.arg_third;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      fp        <= '0;
    end else if (advance) begin
      b_valid   <= a_valid;
      out_valid <= b_valid;
      if (b_valid) begin
        pc <= ex_out.pc_next;
        fp <= ex_out.fp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_item.cmd        <= a_cmd;
      b_item.arg_first  <= a_first;
      b_item.arg_second <= a_second;
      b_item.arg_third  <= a_third;
      b_item.rd_fault0  <= addr_fault(rd_full0);
      b_item.rd_fault1  <= addr_fault(rd_full1);
      if (b_valid) begin
        out_next_pc       <= ex_out.pc_next;
        out_running       <= ex_out.running;
        out_shown_valid   <= ex_out.shown_valid;
        out_shown_offset  <= ex_out.shown_offset;
        out_shown_value   <= ex_out.shown_value;
        out_address_fault <= ex_out.address_fault;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.next_pc       = out_next_pc;
  assign result.running       = out_running;
  assign result.shown_valid   = out_shown_valid;
  assign result.shown_offset  = out_shown_offset;
  assign result.shown_value   = out_shown_value;
  assign result.address_fault = out_address_fault;

endmodule

[rtl/core/sfvm_mem.sv]
`timescale 1ns / 1ps

module sfvm_mem
  import sfvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  addr_t       rd_addr0,
  input  addr_t       rd_addr1,
  output logic [31:0] rd_data0,
  output logic [31:0] rd_data1,
  input  logic        wr_en,
  input  addr_t       wr_addr,
  input  logic [31:0] wr_data,
  output logic        busy
);

  logic [31:0] mem [DATA_DEPTH];
  logic        clearing;
  addr_t       clr_addr;

  assign busy = clearing;

  // After reset every word is written to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + addr_t'(1);
      if (clr_addr == addr_t'(DATA_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read at the address being written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
      rd_data1 <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
    end
  end

endmodule

[rtl/core/sfvm_exec.sv]
`timescale 1ns / 1ps

module sfvm_exec
  import sfvm_pkg::*;
(
  input  exec_in_t    ex_in,
  input  logic [31:0] rd_data0,
  input  logic [31:0] rd_data1,
  input  logic [31:0] pc,
  input  logic [31:0] fp,
  input  logic [15:0] program_length,
  output exec_out_t   ex_out
);

  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] pc_new;
  logic [31:0] pc_inc;
  logic [31:0] wr_off;
  logic [31:0] wr_full;
  logic [31:0] wr_val;
  logic        wr_req;
  logic        wr_fault;
  logic        rd0_used;
  logic        rd1_used;

  assign x = ex_in.rd_fault0 ? 32'd0 : rd_data0;
  assign y = ex_in.rd_fault1 ? 32'd0 : rd_data1;

  always_comb begin
    pc_new              = pc;
    ex_out.fp_next      = fp;
    wr_req              = 1'b0;
    wr_off              = ex_in.arg_first;
    wr_val              = ex_in.arg_second;
    rd0_used            = 1'b0;
    rd1_used            = 1'b0;
    ex_out.shown_valid  = 1'b0;
    ex_out.shown_offset = '0;
    ex_out.shown_value  = '0;
    case (ex_in.cmd)
      CMD_JABS: begin
        pc_new = ex_in.arg_first;
      end
      CMD_JREL: begin
        pc_new = pc + ex_in.arg_first;
      end
      CMD_CALL: begin
        wr_req = 1'b1;
        wr_off = 32'd1;
        wr_val = pc;
        pc_new = ex_in.arg_first;
      end
      CMD_RET: begin
        rd0_used = 1'b1;
        pc_new   = x;
      end
      CMD_PUSH: begin
        wr_req         = 1'b1;
        wr_val         = ex_in.arg_first;
        ex_out.fp_next = fp + ex_in.arg_first;
      end
      CMD_POP: begin
        rd0_used       = 1'b1;
        ex_out.fp_next = fp - x;
      end
      CMD_SET: begin
        wr_req = 1'b1;
      end
      CMD_ADD: begin
        rd0_used = 1'b1;
        rd1_used = 1'b1;
        wr_req   = 1'b1;
        wr_off   = ex_in.arg_third;
        wr_val   = x + y;
      end
      CMD_MUL: begin
        rd0_used = 1'b1;
        rd1_used = 1'b1;
        wr_req   = 1'b1;
        wr_off   = ex_in.arg_third;
        wr_val   = x * y;
      end
      CMD_OUT: begin
        rd0_used            = 1'b1;
        ex_out.shown_valid  = 1'b1;
        ex_out.shown_offset = ex_in.arg_first;
        ex_out.shown_value  = x;
      end
      CMD_JNZ: begin
        rd0_used = 1'b1;
        if (x != 32'd0) begin
          pc_new = pc + ex_in.arg_second;
        end
      end
      default: begin
        pc_new = pc;
      end
    endcase

    wr_full  = fp + wr_off;
    wr_fault = addr_fault(wr_full);
    pc_inc   = pc_new + 32'd1;

    ex_out.pc_next       = pc_inc;
    ex_out.running       = !pc_inc[31] && (pc_inc < {16'd0, program_length});
    ex_out.wr_en         = wr_req && !wr_fault;
    ex_out.wr_addr       = wr_full[ADDR_W-1:0];
    ex_out.wr_data       = wr_val;
    ex_out.address_fault = (rd0_used && ex_in.rd_fault0) ||
                           (rd1_used && ex_in.rd_fault1) ||
                           (wr_req && wr_fault);
  end

endmodule

[rtl/core/sfvm_checker.sv]
`timescale 1ns / 1ps

module sfvm_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_next_pc,
  input logic        result_shown_valid,
  input logic [31:0] result_shown_offset,
  input logic [31:0] result_shown_value
);

  // The data memory is still being cleared right after reset.
  a_no_accept_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item_ready)
    else $error("input accepted during the memory clearing pass");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_next_pc))
    else $error("stalled result changed");

  a_shown_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_shown_valid |-> result_shown_offset == 32'd0 &&
                                            result_shown_value == 32'd0)
    else $error("shown fields set on a non-output instruction");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready ##1 result_ready ##1 result_ready |=> result_valid)
    else $error("result missing three cycles after the transaction");

endmodule

bind stack_frame_vm_execute_core sfvm_checker u_sfvm_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_valid          (item.valid),
  .item_ready          (item.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_next_pc      (result.next_pc),
  .result_shown_valid  (result.shown_valid),
  .result_shown_offset (result.shown_offset),
  .result_shown_value  (result.shown_value)
);

[dv/stack_frame_vm_execute_core_tb.sv]
`timescale 1ns / 1ps

module stack_frame_vm_execute_core_tb;
  import sfvm_pkg::*;

  localparam logic [3:0] CMD_NOP_LOW = 4'd11;
  localparam logic [3:0] CMD_NOP_HIGH = 4'd15;
  localparam int NUM_DIRECTED = 27;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
    logic [31:0] arg_third;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        running;
    logic        shown_valid;
    logic [31:0] shown_offset;
    logic [31:0] shown_value;
    logic        address_fault;
  } vm_result_t;

  typedef struct packed {
    instr_t     ins;
    logic       fixed_exp;
    vm_result_t want;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  sfvm_in_if item_if ();
  sfvm_out_if result_if ();

  stack_frame_vm_execute_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item(item_if),
    .result(result_if)
  );

  logic [31:0] vm_pc;
  logic [31:0] vm_fp;
  logic [15:0] vm_prog_len;
  logic [31:0] vm_mem [DATA_DEPTH];
  logic        step_fault;

  vm_result_t    pending_results[$];
  directed_row_t directed_tab [NUM_DIRECTED];
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   fail_count;
  int unsigned   cycle_count;

  always #1 clk = ~clk;

  function automatic logic [31:0] read_word(input logic [31:0] offset);
    logic [31:0] addr;
    addr = vm_fp + offset;
    if (addr >= 32'(DATA_DEPTH)) begin
      step_fault = 1'b1;
      return 32'd0;
    end
    return vm_mem[addr[ADDR_W-1:0]];
  endfunction

  function automatic void write_word(input logic [31:0] offset, input logic [31:0] value);
    logic [31:0] addr;
    addr = vm_fp + offset;
    if (addr >= 32'(DATA_DEPTH)) begin
      step_fault = 1'b1;
    end else begin
      vm_mem[addr[ADDR_W-1:0]] = value;
    end
  endfunction

  function automatic vm_result_t execute_instr(input instr_t ins);
    vm_result_t r;
    logic [31:0] x;
    logic [31:0] y;
    r = '0;
    step_fault = 1'b0;
    case (ins.cmd)
      CMD_JABS: vm_pc = ins.arg_first;
      CMD_JREL: vm_pc = vm_pc + ins.arg_first;
      CMD_CALL: begin
        write_word(32'd1, vm_pc);
        vm_pc = ins.arg_first;
      end
      CMD_RET: vm_pc = read_word(32'd1);
      CMD_PUSH: begin
        write_word(ins.arg_first, ins.arg_first);
        vm_fp = vm_fp + ins.arg_first;
      end
      CMD_POP: vm_fp = vm_fp - read_word(32'd0);
      CMD_SET: write_word(ins.arg_first, ins.arg_second);
      CMD_ADD: begin
        x = read_word(ins.arg_first);
        y = read_word(ins.arg_second);
        write_word(ins.arg_third, x + y);
      end
      CMD_MUL: begin
        x = read_word(ins.arg_first);
        y = read_word(ins.arg_second);
        write_word(ins.arg_third, x * y);
      end
      CMD_OUT: begin
        r.shown_valid = 1'b1;
        r.shown_offset = ins.arg_first;
        r.shown_value = read_word(ins.arg_first);
      end
      CMD_JNZ: begin
        if (read_word(ins.arg_first) != 32'd0) vm_pc = vm_pc + ins.arg_second;
      end
      default: ;
    endcase
    vm_pc = vm_pc + 32'd1;
    r.next_pc = vm_pc;
    r.running = !vm_pc[31] && (vm_pc < {16'd0, vm_prog_len});
    r.address_fault = step_fault;
    return r;
  endfunction

  function automatic vm_result_t res(input logic [31:0] next_pc, input logic running,
                                     input logic shown_valid, input logic [31:0] shown_offset,
                                     input logic [31:0] shown_value, input logic fault);
    vm_result_t r;
    r.next_pc = next_pc;
    r.running = running;
    r.shown_valid = shown_valid;
    r.shown_offset = shown_offset;
    r.shown_value = shown_value;
    r.address_fault = fault;
    return r;
  endfunction

  function automatic directed_row_t dir_row(input logic [3:0] cmd, input logic [31:0] a,
                                            input logic [31:0] b, input logic [31:0] t,
                                            input logic fixed_exp, input vm_result_t want);
    directed_row_t row;
    row.ins.cmd = cmd;
    row.ins.arg_first = a;
    row.ins.arg_second = b;
    row.ins.arg_third = t;
    row.fixed_exp = fixed_exp;
    row.want = want;
    return row;
  endfunction

  // Offsets are chosen relative to the current frame so most addresses land in memory.
  function automatic logic [31:0] pick_offset();
    int unsigned pick;
    logic [31:0] target;
    pick = $urandom_range(0, 99);
    if (pick < 70) target = $urandom_range(0, 31);
    else if (pick < 90) target = $urandom_range(0, DATA_DEPTH - 1);
    else if (pick < 95) target = DATA_DEPTH + $urandom_range(0, 15);
    else target = $urandom();
    return target - vm_fp;
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    int unsigned pick;
    ins.cmd = CMD_NOP_LOW;
    ins.arg_first = $urandom();
    ins.arg_second = $urandom();
    ins.arg_third = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      ins.cmd = CMD_JABS;
      if ($urandom_range(0, 9) != 0) ins.arg_first = $urandom_range(0, 300);
    end else if (pick < 12) begin
      ins.cmd = CMD_JREL;
      if ($urandom_range(0, 9) != 0) ins.arg_first = $urandom_range(0, 64) - 32;
    end else if (pick < 17) begin
      ins.cmd = CMD_CALL;
      if ($urandom_range(0, 9) != 0) ins.arg_first = $urandom_range(0, 300);
    end else if (pick < 22) begin
      ins.cmd = CMD_RET;
    end else if (pick < 29) begin
      ins.cmd = CMD_PUSH;
      pick = $urandom_range(0, 9);
      if (pick < 5) ins.arg_first = $urandom_range(1, 8);
      else if (pick < 9) ins.arg_first = $urandom_range(0, 48) - vm_fp;
    end else if (pick < 35) begin
      ins.cmd = CMD_POP;
    end else if (pick < 55) begin
      ins.cmd = CMD_SET;
      ins.arg_first = pick_offset();
      if ($urandom_range(0, 1) != 0) ins.arg_second = $urandom_range(0, 300);
    end else if (pick < 77) begin
      ins.cmd = (pick < 67) ? CMD_ADD : CMD_MUL;
      ins.arg_first = pick_offset();
      ins.arg_second = pick_offset();
      ins.arg_third = pick_offset();
    end else if (pick < 87) begin
      ins.cmd = CMD_OUT;
      ins.arg_first = pick_offset();
    end else if (pick < 96) begin
      ins.cmd = CMD_JNZ;
      ins.arg_first = pick_offset();
      if ($urandom_range(0, 9) != 0) ins.arg_second = $urandom_range(0, 64) - 32;
    end else begin
      ins.cmd = 4'($urandom_range(CMD_NOP_LOW, CMD_NOP_HIGH));
    end
    return ins;
  endfunction

  task automatic send_instr(input instr_t ins, input logic fixed_exp, input vm_result_t want);
    vm_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.cmd <= ins.cmd;
    item_if.arg_first <= ins.arg_first;
    item_if.arg_second <= ins.arg_second;
    item_if.arg_third <= ins.arg_third;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    predicted = execute_instr(ins);
    pending_results.push_back(fixed_exp ? want : predicted);
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_prog_len(input logic [15:0] len);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vm_prog_len = len;
  endtask

  task automatic check_result();
    vm_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transaction with no expectation pending");
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    if (result_if.next_pc !== want.next_pc) begin
      $error("next_pc: expected %h, got %h", want.next_pc, result_if.next_pc);
      fail_count++;
    end
    if (result_if.running !== want.running) begin
      $error("running: expected %b, got %b", want.running, result_if.running);
      fail_count++;
    end
    if (result_if.shown_valid !== want.shown_valid) begin
      $error("shown_valid: expected %b, got %b", want.shown_valid, result_if.shown_valid);
      fail_count++;
    end
    if (result_if.shown_offset !== want.shown_offset) begin
      $error("shown_offset: expected %h, got %h", want.shown_offset, result_if.shown_offset);
      fail_count++;
    end
    if (result_if.shown_value !== want.shown_value) begin
      $error("shown_value: expected %h, got %h", want.shown_value, result_if.shown_value);
      fail_count++;
    end
    if (result_if.address_fault !== want.address_fault) begin
      $error("address_fault: expected %b, got %b", want.address_fault,
             result_if.address_fault);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) check_result();
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_len [NUM_PHASES];
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'd0;
    item_if.valid = 1'b0;
    item_if.cmd = CMD_JABS;
    item_if.arg_first = '0;
    item_if.arg_second = '0;
    item_if.arg_third = '0;
    send_idle_pct = 19;
    recv_idle_pct = 56;
    vm_pc = '0;
    vm_fp = '0;
    vm_prog_len = '0;
    foreach (vm_mem[i]) vm_mem[i] = '0;

    // The program length is zero out of reset, so nothing here is running.
    directed_tab[0] = dir_row(CMD_OUT, 0, 0, 0, 1'b1, res(1, 1'b0, 1'b1, 0, 0, 1'b0));
    directed_tab[1] = dir_row(CMD_JABS, 32'h7fffffff, 0, 0, 1'b1,
                              res(32'h80000000, 1'b0, 1'b0, 0, 0, 1'b0));
    directed_tab[2] = dir_row(CMD_JREL, -1, 0, 0, 1'b1,
                              res(32'h80000000, 1'b0, 1'b0, 0, 0, 1'b0));
    directed_tab[3] = dir_row(CMD_JABS, -1, 0, 0, 1'b1, res(0, 1'b0, 1'b0, 0, 0, 1'b0));
    directed_tab[4] = dir_row(CMD_SET, DATA_DEPTH - 1, 32'h7fffffff, 0, 1'b1,
                              res(1, 1'b0, 1'b0, 0, 0, 1'b0));
    directed_tab[5] = dir_row(CMD_SET, DATA_DEPTH, 5, 0, 1'b1,
                              res(2, 1'b0, 1'b0, 0, 0, 1'b1));
    directed_tab[6] = dir_row(CMD_OUT, DATA_DEPTH - 1, 0, 0, 1'b1,
                              res(3, 1'b0, 1'b1, DATA_DEPTH - 1, 32'h7fffffff, 1'b0));
    directed_tab[7] = dir_row(CMD_OUT, -1, 0, 0, 1'b1, res(4, 1'b0, 1'b1, -1, 0, 1'b1));
    directed_tab[8] = dir_row(CMD_SET, 2, 32'h80000000, 0, 1'b0, '0);
    directed_tab[9] = dir_row(CMD_SET, 3, -1, 0, 1'b0, '0);
    directed_tab[10] = dir_row(CMD_ADD, 2, 3, 4, 1'b0, '0);
    directed_tab[11] = dir_row(CMD_MUL, 2, 3, 5, 1'b0, '0);
    directed_tab[12] = dir_row(CMD_ADD, 32'h80000000, DATA_DEPTH - 1, 6, 1'b0, '0);
    directed_tab[13] = dir_row(CMD_MUL, 4, DATA_DEPTH - 1, 2000, 1'b0, '0);
    directed_tab[14] = dir_row(CMD_JNZ, 4, 20, 0, 1'b0, '0);
    directed_tab[15] = dir_row(CMD_JNZ, 0, 20, 0, 1'b0, '0);
    directed_tab[16] = dir_row(CMD_JNZ, 5000, 20, 0, 1'b0, '0);
    directed_tab[17] = dir_row(CMD_CALL, 100, 0, 0, 1'b0, '0);
    directed_tab[18] = dir_row(CMD_RET, 0, 0, 0, 1'b0, '0);
    directed_tab[19] = dir_row(CMD_PUSH, 8, 0, 0, 1'b0, '0);
    directed_tab[20] = dir_row(CMD_OUT, 0, 0, 0, 1'b0, '0);
    directed_tab[21] = dir_row(CMD_POP, 0, 0, 0, 1'b0, '0);
    directed_tab[22] = dir_row(CMD_PUSH, 2000, 0, 0, 1'b0, '0);
    directed_tab[23] = dir_row(CMD_POP, 0, 0, 0, 1'b0, '0);
    directed_tab[24] = dir_row(CMD_RET, 0, 0, 0, 1'b0, '0);
    directed_tab[25] = dir_row(CMD_PUSH, -2000, 0, 0, 1'b0, '0);
    directed_tab[26] = dir_row(CMD_NOP_HIGH, -1, -1, -1, 1'b0, '0);

    phase_len[0] = 16'hffff;
    phase_len[1] = 16'd150;
    phase_len[2] = 16'd1;
    phase_len[3] = 16'd0;
    phase_len[4] = 16'd40;
    phase_len[5] = 16'($urandom_range(0, 65535));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i]) begin
      send_instr(directed_tab[i].ins, directed_tab[i].fixed_exp, directed_tab[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_prog_len(phase_len[ph]);
      repeat (ITEMS_PER_PHASE) send_instr(random_instr(), 1'b0, '0);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[stack_frame_vm_execute_core.f]
rtl/core/sfvm_pkg.sv
rtl/core/sfvm_in_if.sv
rtl/core/sfvm_out_if.sv
rtl/core/sfvm_mem.sv
rtl/core/sfvm_exec.sv
rtl/core/stack_frame_vm_execute_core.sv
rtl/core/sfvm_checker.sv
dv/stack_frame_vm_execute_core_tb.sv
